// ===== rtl/pwd_pkg.sv =====
package pwd_pkg;

  // Result event codes.
  localparam logic [3:0] EV_HANDSHAKE = 4'd0;
  localparam logic [3:0] EV_KEEPALIVE = 4'd1;
  localparam logic [3:0] EV_CHOKE     = 4'd2;
  localparam logic [3:0] EV_UNCHOKE   = 4'd3;
  localparam logic [3:0] EV_INTEREST  = 4'd4;
  localparam logic [3:0] EV_NOTINT    = 4'd5;
  localparam logic [3:0] EV_HAVE      = 4'd6;
  localparam logic [3:0] EV_HAVERANGE = 4'd7;
  localparam logic [3:0] EV_HAVEBAD   = 4'd8;
  localparam logic [3:0] EV_BITFIELD  = 4'd9;
  localparam logic [3:0] EV_REQUEST   = 4'd10;
  localparam logic [3:0] EV_PIECE     = 4'd11;
  localparam logic [3:0] EV_EXT       = 4'd12;
  localparam logic [3:0] EV_CLOSED    = 4'd13;
  localparam logic [3:0] EV_UNKNOWN   = 4'd14;
  localparam logic [3:0] EV_QUERY     = 4'd15;

  // Message type bytes.
  localparam logic [7:0] KIND_CHOKE    = 8'd0;
  localparam logic [7:0] KIND_UNCHOKE  = 8'd1;
  localparam logic [7:0] KIND_INTEREST = 8'd2;
  localparam logic [7:0] KIND_NOTINT   = 8'd3;
  localparam logic [7:0] KIND_HAVE     = 8'd4;
  localparam logic [7:0] KIND_BITFIELD = 8'd5;
  localparam logic [7:0] KIND_REQUEST  = 8'd6;
  localparam logic [7:0] KIND_PIECE    = 8'd7;
  localparam logic [7:0] KIND_EXT      = 8'd20;

  typedef logic [3:0]  event_t;
  typedef logic [7:0]  byte_t;
  typedef logic [12:0] query_t;
  typedef logic [31:0] word_t;

endpackage

// ===== rtl/pwd_in_if.sv =====
interface pwd_in_if;
  import pwd_pkg::*;

  logic   valid;
  logic   ready;
  logic   mode;
  byte_t  data_byte;
  query_t query_piece;

  modport source (output valid, mode, data_byte, query_piece, input ready);
  modport sink (input valid, mode, data_byte, query_piece, output ready);
endinterface

// ===== rtl/pwd_out_if.sv =====
interface pwd_out_if;
  import pwd_pkg::*;

  logic   valid;
  logic   ready;
  event_t event_res;
  word_t  piece_index;
  word_t  block_offset;
  byte_t  payload_byte;
  logic   last;
  logic   has_bit;
  logic   choked;
  logic   interested;

  modport source (output valid, event_res, piece_index, block_offset, payload_byte, last,
                  has_bit, choked, interested, input ready);
  modport sink (input valid, event_res, piece_index, block_offset, payload_byte, last,
                has_bit, choked, interested, output ready);
endinterface

// ===== rtl/pwd_ram.sv =====
module pwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port; a read at a written address sees old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/peer_wire_message_deframer.sv =====
// Peer wire message deframer, receive side.
// in_ch carries one transaction per received byte (mode 0) or a piece query
// (mode 1). out_ch carries at most one result transaction per input.
// Both channels use valid/ready; a transaction moves when both are high.
// The block takes one input per cycle unless the receiver stalls. An input is
// registered in the input stage, decoded against the frame state, and its result
// is loaded into the output register when the decode stage advances. The result
// stage holds the registered read of the bitfield RAM, which serves queries and
// the read-modify-write of have messages; a have bit is written when its result
// leaves.
// When the receiver stalls, the output register holds and the decode stage
// stops, so in_ch.ready drops once one more input is waiting.
// Reset (rst_n low, synchronous) returns to the handshake phase with the
// peer choked and not interested and the stored bitfield length at zero.
// The bitfield RAM needs no clearing pass: only bytes below the stored
// length, all written since the last bitfield began, are ever used.
module peer_wire_message_deframer #(
  parameter int HANDSHAKE_BYTES = 68,
  parameter int BITFIELD_BYTES = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  pwd_in_if.sink           in_ch,
  pwd_out_if.source        out_ch
);
  import pwd_pkg::*;

  localparam int AW  = (BITFIELD_BYTES > 1) ? $clog2(BITFIELD_BYTES) : 1;
  localparam int BLW = $clog2(BITFIELD_BYTES + 1);
  localparam logic [6:0] HS_LAST = 7'(HANDSHAKE_BYTES);
  localparam logic [31:0] BF_DEPTH = 32'(BITFIELD_BYTES);

  localparam logic [2:0] PH_HS      = 3'd0;
  localparam logic [2:0] PH_LEN0    = 3'd1;
  localparam logic [2:0] PH_LEN1    = 3'd2;
  localparam logic [2:0] PH_LEN2    = 3'd3;
  localparam logic [2:0] PH_LEN3    = 3'd4;
  localparam logic [2:0] PH_TYPE    = 3'd5;
  localparam logic [2:0] PH_PAYLOAD = 3'd6;

  // Input stage.
  logic   a_valid_r;
  logic   a_mode_r;
  byte_t  a_byte_r;
  query_t a_q_r;

  // Frame state.
  logic [2:0]     phase_r, phase_nxt;
  logic [6:0]     hs_r, hs_nxt;
  word_t          len_r, len_nxt;
  word_t          rem_r, rem_nxt;
  word_t          pos_r, pos_nxt;
  byte_t          kind_r, kind_nxt;
  logic [63:0]    hdr_r, hdr_nxt;
  logic           choke_r, choke_nxt;
  logic           int_r, int_nxt;
  logic           closed_r, closed_nxt;
  logic [BLW-1:0] bfl_r, bfl_nxt;

  // Result stage.
  logic           b_valid_r;
  event_t         b_ev_r;
  word_t          b_idx_r;
  word_t          b_off_r;
  byte_t          b_pb_r;
  logic           b_last_r;
  logic           b_choke_r;
  logic           b_int_r;
  logic           b_qry_r;
  logic           b_inrange_r;
  logic [2:0]     b_bit_r;
  logic           b_havewr_r;
  logic [AW-1:0]  b_addr_r;

  // Decode outputs.
  logic           emit;
  event_t         ev;
  word_t          idx;
  word_t          off;
  byte_t          pb;
  logic           lst;
  logic           qry;
  logic           inrange;
  logic [2:0]     bitsel;
  logic           havewr;
  logic           bf_we;
  logic [AW-1:0]  bf_addr;
  logic [AW-1:0]  rd_addr;
  logic           fin;
  logic           done;
  word_t          piece;

  // RAM and bypass.
  logic           a_adv;
  logic           b_fire;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  byte_t          ram_wdata;
  byte_t          ram_rdata;
  logic           byp_hit_r;
  byte_t          byp_data_r;
  byte_t          bdata;

  assign b_fire      = b_valid_r && out_ch.ready;
  assign a_adv       = a_valid_r && (!b_valid_r || out_ch.ready);
  assign in_ch.ready = !a_valid_r || a_adv;

  // Decode one item against the frame state.
  always_comb begin
    phase_nxt  = phase_r;
    hs_nxt     = hs_r;
    len_nxt    = len_r;
    rem_nxt    = rem_r;
    pos_nxt    = pos_r;
    kind_nxt   = kind_r;
    hdr_nxt    = hdr_r;
    choke_nxt  = choke_r;
    int_nxt    = int_r;
    closed_nxt = closed_r;
    bfl_nxt    = bfl_r;
    emit       = 1'b0;
    ev         = EV_HANDSHAKE;
    idx        = '0;
    off        = '0;
    pb         = '0;
    lst        = 1'b0;
    qry        = 1'b0;
    inrange    = 1'b0;
    bitsel     = '0;
    havewr     = 1'b0;
    bf_we      = 1'b0;
    bf_addr    = '0;
    rd_addr    = '0;
    fin        = 1'b0;
    done       = 1'b0;
    piece      = '0;
    if (a_mode_r) begin
      qry     = 1'b1;
      emit    = 1'b1;
      ev      = EV_QUERY;
      idx     = 32'(a_q_r);
      inrange = 32'(a_q_r[12:3]) < 32'(bfl_r);
      bitsel  = a_q_r[2:0];
      rd_addr = a_q_r[AW+2:3];
    end else if (!closed_r) begin
      unique case (phase_r)
        PH_HS: begin
          hs_nxt = hs_r + 7'd1;
          if (hs_nxt >= HS_LAST) begin
            phase_nxt = PH_LEN0;
            emit      = 1'b1;
            ev        = EV_HANDSHAKE;
          end
        end
        PH_LEN0, PH_LEN1, PH_LEN2: begin
          len_nxt   = {len_r[23:0], a_byte_r};
          phase_nxt = phase_r + 3'd1;
        end
        PH_LEN3: begin
          len_nxt = {len_r[23:0], a_byte_r};
          if (len_nxt == '0) begin
            phase_nxt = PH_LEN0;
            emit      = 1'b1;
            ev        = EV_KEEPALIVE;
          end else begin
            phase_nxt = PH_TYPE;
          end
        end
        PH_TYPE: begin
          kind_nxt = a_byte_r;
          rem_nxt  = len_r - 32'd1;
          hdr_nxt  = '0;
          pos_nxt  = '0;
          if (a_byte_r == KIND_BITFIELD) begin
            bfl_nxt = '0;
          end
          if (rem_nxt == '0) begin
            fin = 1'b1;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          pos_nxt = pos_r + 32'd1;
          rem_nxt = rem_r - 32'd1;
          done    = (rem_nxt == '0);
          if (kind_r == KIND_PIECE) begin
            if (pos_r < 32'd8) begin
              hdr_nxt = {hdr_r[55:0], a_byte_r};
            end else begin
              emit = 1'b1;
              ev   = EV_PIECE;
              idx  = hdr_r[63:32];
              off  = hdr_r[31:0] + (pos_r - 32'd8);
              pb   = a_byte_r;
              lst  = done;
            end
            if (done) begin
              phase_nxt = PH_LEN0;
            end
          end else if (kind_r == KIND_EXT) begin
            emit = 1'b1;
            ev   = EV_EXT;
            pb   = a_byte_r;
            lst  = done;
            if (done) begin
              phase_nxt = PH_LEN0;
            end
          end else begin
            if (kind_r == KIND_HAVE && pos_r < 32'd4) begin
              hdr_nxt = {hdr_r[55:0], a_byte_r};
            end
            if (kind_r == KIND_BITFIELD && pos_r < BF_DEPTH) begin
              bf_we   = 1'b1;
              bf_addr = pos_r[AW-1:0];
              bfl_nxt = BLW'(pos_r + 32'd1);
            end
            fin = done;
          end
        end
        default: begin
          phase_nxt = PH_LEN0;
          len_nxt   = '0;
        end
      endcase

      // End of a message with no streamed payload bytes.
      if (fin) begin
        phase_nxt = PH_LEN0;
        piece     = hdr_nxt[31:0];
        unique case (kind_nxt)
          KIND_CHOKE: begin
            choke_nxt = 1'b1;
            emit      = 1'b1;
            ev        = EV_CHOKE;
          end
          KIND_UNCHOKE: begin
            if (choke_r) begin
              choke_nxt = 1'b0;
              emit      = 1'b1;
              ev        = EV_UNCHOKE;
            end
          end
          KIND_INTEREST: begin
            int_nxt = 1'b1;
            emit    = 1'b1;
            ev      = EV_INTEREST;
          end
          KIND_NOTINT: begin
            int_nxt = 1'b0;
            emit    = 1'b1;
            ev      = EV_NOTINT;
          end
          KIND_HAVE: begin
            emit = 1'b1;
            if (len_r != 32'd5) begin
              ev = EV_HAVEBAD;
            end else if ({3'b000, piece[31:3]} < 32'(bfl_r)) begin
              ev      = EV_HAVE;
              idx     = piece;
              havewr  = 1'b1;
              bitsel  = piece[2:0];
              rd_addr = piece[AW+2:3];
            end else begin
              ev  = EV_HAVERANGE;
              idx = piece;
            end
          end
          KIND_BITFIELD: begin
            emit = 1'b1;
            ev   = EV_BITFIELD;
          end
          KIND_REQUEST: begin
            emit = 1'b1;
            ev   = EV_REQUEST;
          end
          KIND_PIECE: begin
            emit = 1'b0;
          end
          KIND_EXT: begin
            closed_nxt = 1'b1;
            emit       = 1'b1;
            ev         = EV_CLOSED;
          end
          default: begin
            emit = 1'b1;
            ev   = EV_UNKNOWN;
          end
        endcase
      end
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      a_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      a_mode_r <= in_ch.mode;
      a_byte_r <= in_ch.data_byte;
      a_q_r    <= in_ch.query_piece;
    end
  end

  // Frame state advances as each item leaves the input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HS;
      hs_r     <= '0;
      len_r    <= '0;
      rem_r    <= '0;
      pos_r    <= '0;
      kind_r   <= '0;
      hdr_r    <= '0;
      choke_r  <= 1'b1;
      int_r    <= 1'b0;
      closed_r <= 1'b0;
      bfl_r    <= '0;
    end else if (a_adv) begin
      phase_r  <= phase_nxt;
      hs_r     <= hs_nxt;
      len_r    <= len_nxt;
      rem_r    <= rem_nxt;
      pos_r    <= pos_nxt;
      kind_r   <= kind_nxt;
      hdr_r    <= hdr_nxt;
      choke_r  <= choke_nxt;
      int_r    <= int_nxt;
      closed_r <= closed_nxt;
      bfl_r    <= bfl_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (a_adv) begin
      b_valid_r <= emit;
    end else if (b_fire) begin
      b_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_ev_r      <= ev;
      b_idx_r     <= idx;
      b_off_r     <= off;
      b_pb_r      <= pb;
      b_last_r    <= lst;
      b_choke_r   <= choke_nxt;
      b_int_r     <= int_nxt;
      b_qry_r     <= qry;
      b_inrange_r <= inrange;
      b_bit_r     <= bitsel;
      b_havewr_r  <= havewr;
      b_addr_r    <= rd_addr;
    end
  end

  // Bitfield store: bitfield bytes write on decode, have bits write as their result leaves.
  assign ram_we    = bf_we && a_adv || b_fire && b_havewr_r;
  assign ram_waddr = (b_fire && b_havewr_r) ? b_addr_r : bf_addr;
  assign ram_wdata = (b_fire && b_havewr_r) ? (bdata | (8'h80 >> b_bit_r)) : a_byte_r;

  pwd_ram #(
    .WIDTH (8),
    .DEPTH (BITFIELD_BYTES)
  ) u_bits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (a_adv),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // Forward a write that lands in the same cycle as the read of that byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_hit_r <= 1'b0;
    end else if (a_adv) begin
      byp_hit_r <= ram_we && (ram_waddr == rd_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) begin
      byp_data_r <= ram_wdata;
    end
  end

  assign bdata = byp_hit_r ? byp_data_r : ram_rdata;

  // Output channel.
  assign out_ch.valid        = b_valid_r;
  assign out_ch.event_res    = b_ev_r;
  assign out_ch.piece_index  = b_idx_r;
  assign out_ch.block_offset = b_off_r;
  assign out_ch.payload_byte = b_pb_r;
  assign out_ch.last         = b_last_r;
  assign out_ch.has_bit      = b_qry_r && b_inrange_r && bdata[3'd7 - b_bit_r];
  assign out_ch.choked       = b_choke_r;
  assign out_ch.interested   = b_int_r;

endmodule

// ===== sim/peer_wire_message_deframer_tb.sv =====
module peer_wire_message_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pwd_pkg::*;

  localparam int HS_BYTES = 68;
  localparam int BF_BYTES = 1024;
  localparam int CYCLE_LIMIT = 600000;
  localparam int LONG_HOLD = 300;
  localparam int NUM_MSGS = 64;
  localparam logic [2:0] PH_HANDSHAKE = 3'd0;
  localparam logic [2:0] PH_LEN_LAST = 3'd4;
  localparam logic [2:0] PH_TYPE = 3'd5;
  localparam logic [2:0] PH_PAYLOAD = 3'd6;
  localparam logic MODE_STREAM = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef struct packed {
    event_t ev;
    word_t  idx;
    word_t  off;
    byte_t  pb;
    logic   last;
    logic   hb;
    logic   ch;
    logic   it;
  } peer_event_t;

  typedef struct {
    logic   mode;
    byte_t  b;
    query_t q;
    bit     typed;
    event_t ev;
    word_t  idx;
    logic   hb;
    logic   ch;
    logic   it;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   failed = 1'b0;
  bit   hold_receiver = 1'b0;
  bit   no_idle = 1'b0;
  int   cycles = 0;

  pwd_in_if  in_ch();
  pwd_out_if out_ch();

  peer_wire_message_deframer u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #5 clk = ~clk;

  // Shadow state of the deframer.
  byte_t       bits_mem [BF_BYTES];
  int unsigned bf_len;
  int unsigned hs_count;
  logic [2:0]  phase;
  word_t       len_acc;
  word_t       remaining;
  byte_t       kind;
  logic [63:0] hdr_acc;
  logic        choke_f;
  logic        interest_f;
  logic        closed_f;

  peer_event_t pending_events[$];

  // End of a message: apply its effect and build its event.
  function automatic bit finish_msg(output peer_event_t r);
    word_t       piece;
    int unsigned bix;
    r = '0;
    phase = 3'd1;
    case (kind)
      KIND_CHOKE: begin
        choke_f = 1'b1;
        r.ev = EV_CHOKE;
      end
      KIND_UNCHOKE: begin
        if (!choke_f) return 1'b0;
        choke_f = 1'b0;
        r.ev = EV_UNCHOKE;
      end
      KIND_INTEREST: begin
        interest_f = 1'b1;
        r.ev = EV_INTEREST;
      end
      KIND_NOTINT: begin
        interest_f = 1'b0;
        r.ev = EV_NOTINT;
      end
      KIND_HAVE: begin
        if (len_acc != 32'd5) begin
          r.ev = EV_HAVEBAD;
        end else begin
          piece = hdr_acc[31:0];
          bix = piece / 8;
          r.idx = piece;
          if (bix < bf_len && bix < BF_BYTES) begin
            bits_mem[bix][7 - piece % 8] = 1'b1;
            r.ev = EV_HAVE;
          end else begin
            r.ev = EV_HAVERANGE;
          end
        end
      end
      KIND_BITFIELD: r.ev = EV_BITFIELD;
      KIND_REQUEST: r.ev = EV_REQUEST;
      KIND_PIECE: return 1'b0;
      KIND_EXT: begin
        closed_f = 1'b1;
        r.ev = EV_CLOSED;
      end
      default: r.ev = EV_UNKNOWN;
    endcase
    return 1'b1;
  endfunction

  // Advance the shadow state by one input; returns 1 when a result is due.
  function automatic bit step_deframer(input logic mode, input byte_t b, input query_t q,
                                       output peer_event_t r);
    int unsigned ix;
    word_t       pos;
    bit          done;
    bit          got;
    r = '0;
    got = 1'b0;
    if (mode == MODE_QUERY) begin
      ix = q / 8;
      r.ev = EV_QUERY;
      r.idx = word_t'(q);
      if (ix < bf_len && ix < BF_BYTES) r.hb = bits_mem[ix][7 - q % 8];
      got = 1'b1;
    end else if (closed_f) begin
      got = 1'b0;
    end else if (phase == PH_HANDSHAKE) begin
      hs_count = (hs_count + 1) & 32'h7f;
      if (hs_count >= HS_BYTES) begin
        phase = 3'd1;
        r.ev = EV_HANDSHAKE;
        got = 1'b1;
      end
    end else if (phase <= PH_LEN_LAST) begin
      len_acc = {len_acc[23:0], b};
      if (phase < PH_LEN_LAST) begin
        phase = phase + 3'd1;
      end else if (len_acc == 0) begin
        phase = 3'd1;
        r.ev = EV_KEEPALIVE;
        got = 1'b1;
      end else begin
        phase = PH_TYPE;
      end
    end else if (phase == PH_TYPE) begin
      kind = b;
      remaining = len_acc - 1;
      hdr_acc = '0;
      if (kind == KIND_BITFIELD) bf_len = 0;
      if (remaining == 0) got = finish_msg(r);
      else phase = PH_PAYLOAD;
    end else begin
      pos = (len_acc - 1) - remaining;
      remaining = remaining - 1;
      done = (remaining == 0);
      if (kind == KIND_PIECE) begin
        if (done) phase = 3'd1;
        if (pos < 8) begin
          hdr_acc = {hdr_acc[55:0], b};
        end else begin
          r.ev = EV_PIECE;
          r.idx = hdr_acc[63:32];
          r.off = hdr_acc[31:0] + (pos - 8);
          r.pb = b;
          r.last = done;
          got = 1'b1;
        end
      end else if (kind == KIND_EXT) begin
        if (done) phase = 3'd1;
        r.ev = EV_EXT;
        r.pb = b;
        r.last = done;
        got = 1'b1;
      end else begin
        if (kind == KIND_HAVE && pos < 4) hdr_acc = {hdr_acc[55:0], b};
        if (kind == KIND_BITFIELD && pos < BF_BYTES) begin
          bits_mem[pos] = b;
          bf_len = pos + 1;
        end
        if (done) got = finish_msg(r);
      end
    end
    r.ch = choke_f;
    r.it = interest_f;
    return got;
  endfunction

  // Offer one transaction and wait for its acceptance.
  task automatic offer(input logic mode, input byte_t b, input query_t q, output peer_event_t r,
                       output bit got);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= mode;
    in_ch.data_byte <= b;
    in_ch.query_piece <= q;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    got = step_deframer(mode, b, q, r);
  endtask

  task automatic send(input logic mode, input byte_t b, input query_t q);
    peer_event_t r;
    bit          got;
    offer(mode, b, q, r, got);
    if (got) pending_events = {pending_events, r};
  endtask

  // Stream byte, sometimes preceded by a piece query.
  task automatic stream_byte(input byte_t b);
    query_t q;
    if ($urandom_range(0, 7) == 0) begin
      if (bf_len > 0 && $urandom_range(0, 1)) q = query_t'($urandom_range(0, bf_len * 8 - 1));
      else q = query_t'($urandom);
      send(MODE_QUERY, 8'h00, q);
    end
    send(MODE_STREAM, b, 13'd0);
  endtask

  task automatic send_frame(input word_t len, input byte_t k, input byte_t body[$]);
    stream_byte(len[31:24]);
    stream_byte(len[23:16]);
    stream_byte(len[15:8]);
    stream_byte(len[7:0]);
    if (len != 0) stream_byte(k);
    foreach (body[i]) stream_byte(body[i]);
  endtask

  // One random message; some are have messages of the wrong length or of an unknown kind.
  task automatic random_message(input bit long_bitfield);
    byte_t body[$];
    byte_t k;
    word_t piece;
    int    n;
    int    sel;
    sel = long_bitfield ? 5 : $urandom_range(0, 11);
    body = {};
    case (sel)
      0, 1: k = byte_t'($urandom_range(0, 3));
      2: begin
        k = KIND_HAVE;
        if ($urandom_range(0, 3) != 0 && bf_len > 0) piece = $urandom_range(0, bf_len * 8 - 1);
        else piece = $urandom;
        for (int i = 3; i >= 0; i--) body = {body, piece[i*8 +: 8]};
      end
      3: begin
        k = KIND_HAVE;
        n = $urandom_range(0, 7);
        if (n >= 4) n++;
        repeat (n) body = {body, byte_t'($urandom)};
      end
      4, 5: begin
        k = KIND_BITFIELD;
        n = long_bitfield ? BF_BYTES + 6 : $urandom_range(1, 12);
        repeat (n) body = {body, byte_t'($urandom)};
      end
      6: begin
        k = KIND_REQUEST;
        repeat (12) body = {body, byte_t'($urandom)};
      end
      7, 8: begin
        k = KIND_PIECE;
        n = $urandom_range(0, 3) == 0 ? $urandom_range(0, 8) : $urandom_range(9, 14);
        repeat (n) body = {body, byte_t'($urandom)};
      end
      9: begin
        k = KIND_EXT;
        repeat ($urandom_range(1, 5)) body = {body, byte_t'($urandom)};
      end
      10: begin
        do k = byte_t'($urandom); while (k <= KIND_PIECE || k == KIND_EXT);
        repeat ($urandom_range(0, 4)) body = {body, byte_t'($urandom)};
      end
      default: begin
        send_frame(32'd0, 8'h00, body);
        return;
      end
    endcase
    send_frame(word_t'(body.size() + 1), k, body);
  endtask

  // Directed rows that follow the handshake.
  stim_row_t rows[$] = '{
    '{MODE_QUERY, 8'h00, 13'h1fff, 1'b1, EV_QUERY, 32'h1fff, 1'b0, 1'b1, 1'b0},
    '{MODE_STREAM, 8'h00, 13'd0, 1'b0, EV_QUERY, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_STREAM, 8'h00, 13'd0, 1'b0, EV_QUERY, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_STREAM, 8'h00, 13'd0, 1'b0, EV_QUERY, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_STREAM, 8'h00, 13'd0, 1'b1, EV_KEEPALIVE, 0, 1'b0, 1'b1, 1'b0},
    '{MODE_STREAM, 8'h00, 13'd0, 1'b0, EV_QUERY, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_STREAM, 8'h00, 13'd0, 1'b0, EV_QUERY, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_STREAM, 8'h00, 13'd0, 1'b0, EV_QUERY, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_STREAM, 8'h01, 13'd0, 1'b0, EV_QUERY, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_STREAM, KIND_UNCHOKE, 13'd0, 1'b1, EV_UNCHOKE, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_STREAM, 8'h00, 13'd0, 1'b0, EV_QUERY, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_STREAM, 8'h00, 13'd0, 1'b0, EV_QUERY, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_STREAM, 8'h00, 13'd0, 1'b0, EV_QUERY, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_STREAM, 8'h01, 13'd0, 1'b0, EV_QUERY, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_STREAM, KIND_UNCHOKE, 13'd0, 1'b0, EV_QUERY, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_STREAM, 8'h00, 13'd0, 1'b0, EV_QUERY, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_STREAM, 8'h00, 13'd0, 1'b0, EV_QUERY, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_STREAM, 8'h00, 13'd0, 1'b0, EV_QUERY, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_STREAM, 8'h05, 13'd0, 1'b0, EV_QUERY, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_STREAM, KIND_HAVE, 13'd0, 1'b0, EV_QUERY, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_STREAM, 8'hff, 13'd0, 1'b0, EV_QUERY, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_STREAM, 8'hff, 13'd0, 1'b0, EV_QUERY, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_STREAM, 8'hff, 13'd0, 1'b0, EV_QUERY, 0, 1'b0, 1'b0, 1'b0},
    '{MODE_STREAM, 8'hff, 13'd0, 1'b1, EV_HAVERANGE, 32'hffffffff, 1'b0, 1'b0, 1'b0},
    '{MODE_QUERY, 8'h00, 13'd0, 1'b1, EV_QUERY, 0, 1'b0, 1'b0, 1'b0}
  };

  // Stimulus.
  initial begin
    peer_event_t r;
    bit          got;
    byte_t       no_body[$];
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_STREAM;
    in_ch.data_byte = '0;
    in_ch.query_piece = '0;
    bf_len = 0;
    hs_count = 0;
    phase = PH_HANDSHAKE;
    len_acc = '0;
    remaining = '0;
    kind = '0;
    hdr_acc = '0;
    choke_f = 1'b1;
    interest_f = 1'b0;
    closed_f = 1'b0;
    foreach (bits_mem[i]) bits_mem[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Query before the handshake, then the handshake itself.
    send(MODE_QUERY, 8'h00, 13'd0);
    for (int i = 0; i < HS_BYTES; i++) send(MODE_STREAM, byte_t'($urandom), 13'd0);

    foreach (rows[i]) begin
      offer(rows[i].mode, rows[i].b, rows[i].q, r, got);
      if (rows[i].typed) begin
        r = '0;
        r.ev = rows[i].ev;
        r.idx = rows[i].idx;
        r.hb = rows[i].hb;
        r.ch = rows[i].ch;
        r.it = rows[i].it;
        pending_events = {pending_events, r};
      end else if (got) begin
        pending_events = {pending_events, r};
      end
    end

    // Random messages; one stretch with no idling on either side, one long receiver hold.
    for (int m = 0; m < NUM_MSGS; m++) begin
      no_idle = (m >= 20 && m < 35);
      if (m == 25) hold_receiver = 1'b1;
      if (m == 45) begin
        in_ch.valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
      end
      random_message(m == 50);
    end
    no_idle = 1'b0;

    // Empty extended message closes the stream; later bytes are dropped.
    send_frame(32'd1, KIND_EXT, no_body);
    repeat (8) stream_byte(byte_t'($urandom));
    repeat (8) send(MODE_QUERY, 8'h00, query_t'($urandom));
    in_ch.valid <= 1'b0;

    while (pending_events.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (!failed) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Result side: random stalls and one long hold-off.
  initial begin
    peer_event_t want;
    peer_event_t seen;
    int          gap;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_receiver) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_receiver = 1'b0;
      end
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      seen = '{out_ch.event_res, out_ch.piece_index, out_ch.block_offset, out_ch.payload_byte,
               out_ch.last, out_ch.has_bit, out_ch.choked, out_ch.interested};
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result ev=%0d", $time, seen.ev);
        failed = 1'b1;
      end else begin
        want = pending_events.pop_front();
        if (seen !== want) begin
          $display("%0t: mismatch expected ev=%0d idx=%h off=%h pb=%h last=%b hb=%b ch=%b it=%b",
                   $time, want.ev, want.idx, want.off, want.pb, want.last, want.hb, want.ch,
                   want.it);
          $display("%0t:          actual ev=%0d idx=%h off=%h pb=%h last=%b hb=%b ch=%b it=%b",
                   $time, seen.ev, seen.idx, seen.off, seen.pb, seen.last, seen.hb, seen.ch,
                   seen.it);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule

// ===== files.f =====
rtl/pwd_pkg.sv
rtl/pwd_in_if.sv
rtl/pwd_out_if.sv
rtl/pwd_ram.sv
rtl/peer_wire_message_deframer.sv
sim/peer_wire_message_deframer_tb.sv
